// ----- design/afd_pkg.sv -----
`default_nettype none

package afd_pkg;

  // default sizes
  localparam int AFD_FRAME_BYTES   = 24;
  localparam int AFD_PAYLOAD_BYTES = 8;

  // framing constants
  localparam logic [7:0] ESC_BYTE          = 8'h7D;
  localparam logic [7:0] ESC_XOR           = 8'h20;
  localparam logic [7:0] CSUM_BASE         = 8'hFF;
  localparam logic [7:0] TYPE_RX_PACKET    = 8'h90;
  localparam logic [7:0] TYPE_MODEM_STATUS = 8'h8A;

  // fixed field positions in the decoded frame
  localparam int POS_TYPE    = 3;
  localparam int POS_LONG    = 4;
  localparam int POS_SHORT   = 12;
  localparam int POS_OPTIONS = 14;
  localparam int POS_PAYLOAD = 15;
  localparam int VIEW_BYTES  = 23;

  // result status codes
  typedef enum logic [2:0] {
    ST_RX_OK          = 3'd0,
    ST_CSUM_ERR       = 3'd1,
    ST_MODEM_OK       = 3'd2,
    ST_TYPE_UNHANDLED = 3'd3,
    ST_TOO_LONG       = 3'd4
  } afd_status_t;

  // one decoded result word
  typedef struct packed {
    afd_status_t  status;
    logic [7:0]   frame_type;
    logic [63:0]  long_address;
    logic [15:0]  short_address;
    logic [7:0]   options;
    logic [63:0]  payload;
  } afd_result_t;

endpackage

`default_nettype wire

// ----- design/afd_in_if.sv -----
`default_nettype none

interface afd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;

  modport source (output valid, output rx_byte, output buffer_start, input ready);
  modport sink   (input valid, input rx_byte, input buffer_start, output ready);
endinterface

`default_nettype wire

// ----- design/afd_out_if.sv -----
`default_nettype none

interface afd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [63:0] long_address;
  logic [15:0] short_address;
  logic [7:0]  options;
  logic [63:0] payload;

  modport source (output valid, output status, output frame_type, output long_address,
                  output short_address, output options, output payload, input ready);
  modport sink   (input valid, input status, input frame_type, input long_address,
                  input short_address, input options, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/api_frame_deframer.sv -----
// api frame deframer: unescapes received bytes and decodes one frame per buffer
// an accepted input word is held in the input register; its decoded result then loads the result register
// throughput: one input word per cycle; a stalled result register holds the input side
// a result word is produced by the checksum byte or by the type byte itself
// reset: synchronous active-low, clears valid flags and decoder state; decoding then
//   starts at byte 0 as if a buffer had started
`default_nettype none

module api_frame_deframer import afd_pkg::*; #(
  parameter int FRAME_BYTES   = AFD_FRAME_BYTES,
  parameter int PAYLOAD_BYTES = AFD_PAYLOAD_BYTES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  afd_in_if.sink     in_if,
  afd_out_if.source  out_if
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        out_vld_r;
  afd_result_t out_r;

  logic        advance;
  logic        step;
  logic        emit;
  afd_result_t result;

  // pipeline handshake
  assign advance     = !out_vld_r || out_if.ready;
  assign step        = in_vld_r && advance;
  assign in_if.ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r  <= in_if.rx_byte;
      in_start_r <= in_if.buffer_start;
    end
  end

  afd_core #(
    .FRAME_BYTES   (FRAME_BYTES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_byte_r),
    .buffer_start (in_start_r),
    .result       (result),
    .emit         (emit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= result;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.status        = out_r.status;
  assign out_if.frame_type    = out_r.frame_type;
  assign out_if.long_address  = out_r.long_address;
  assign out_if.short_address = out_r.short_address;
  assign out_if.options       = out_r.options;
  assign out_if.payload       = out_r.payload;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.status <= ST_TOO_LONG)
    else $error("result status out of range");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.status != ST_RX_OK |->
      out_r.long_address == '0 && out_r.short_address == '0 && out_r.payload == '0)
    else $error("address or payload set on a non-receive result");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a word under stall");

endmodule

`default_nettype wire

// ----- design/afd_core.sv -----
`default_nettype none

module afd_core import afd_pkg::*; #(
  parameter int FRAME_BYTES   = AFD_FRAME_BYTES,
  parameter int PAYLOAD_BYTES = AFD_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        buffer_start,
  output afd_result_t      result,
  output logic             emit
);

  localparam int IDX_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  // decoder state
  logic                   esc_r, esc_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [15:0]            len_r, len_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic                   done_r, done_nxt;
  logic [FRAME_BYTES-1:0] vld_r, vld_nxt;
  logic [7:0]             store_r [FRAME_BYTES];

  // working values after an optional buffer restart
  logic [IDX_W-1:0]       cur_idx;
  logic [15:0]            cur_len;
  logic [7:0]             cur_sum;
  logic                   cur_esc;
  logic                   cur_done;
  logic [FRAME_BYTES-1:0] cur_vld;

  logic [7:0]             dec_byte;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [16:0]            j_ext;
  logic [16:0]            last_pos;
  afd_status_t            st;
  logic [7:0]             view [VIEW_BYTES];

  // restart view of the state
  assign cur_idx  = buffer_start ? '0 : idx_r;
  assign cur_len  = buffer_start ? '0 : len_r;
  assign cur_sum  = buffer_start ? '0 : sum_r;
  assign cur_esc  = buffer_start ? 1'b0 : esc_r;
  assign cur_done = buffer_start ? 1'b0 : done_r;
  assign cur_vld  = buffer_start ? '0 : vld_r;

  assign j_ext    = 17'(cur_idx);
  assign last_pos = {1'b0, cur_len} + 17'd3;
  assign wr_addr  = cur_idx[ADDR_W-1:0];

  // unescape, count, accumulate and decide
  always_comb begin
    esc_nxt  = cur_esc;
    idx_nxt  = cur_idx;
    len_nxt  = cur_len;
    sum_nxt  = cur_sum;
    dec_byte = rx_byte;
    wr_en    = 1'b0;
    emit     = 1'b0;
    st       = ST_RX_OK;
    if (!cur_done) begin
      if (rx_byte == ESC_BYTE && !(cur_idx == '0 && !cur_esc)) begin
        esc_nxt = 1'b1;
      end else begin
        if (cur_esc) begin
          dec_byte = rx_byte ^ ESC_XOR;
        end
        esc_nxt = 1'b0;
        wr_en   = (j_ext < 17'(FRAME_BYTES));
        if (j_ext < 17'(FRAME_BYTES)) begin
          idx_nxt = cur_idx + 1'b1;
        end
        if (j_ext == 17'd1) begin
          len_nxt = {dec_byte, cur_len[7:0]};
        end else if (j_ext == 17'd2) begin
          len_nxt = {cur_len[15:8], dec_byte};
        end
        if (j_ext == 17'(POS_TYPE)) begin
          sum_nxt = cur_sum + dec_byte;
          if (dec_byte != TYPE_RX_PACKET && dec_byte != TYPE_MODEM_STATUS) begin
            emit = 1'b1;
            st   = ST_TYPE_UNHANDLED;
          end else if ({1'b0, cur_len} + 17'd4 > 17'(FRAME_BYTES)) begin
            emit = 1'b1;
            st   = ST_TOO_LONG;
          end
        end else if (j_ext > 17'(POS_TYPE) && j_ext < last_pos) begin
          sum_nxt = cur_sum + dec_byte;
        end
        // checksum byte closes the frame
        if (!emit && j_ext >= 17'(POS_TYPE) && j_ext == last_pos) begin
          emit = 1'b1;
          if (CSUM_BASE - sum_nxt != dec_byte) begin
            st = ST_CSUM_ERR;
          end else if (view[POS_TYPE] == TYPE_RX_PACKET) begin
            st = ST_RX_OK;
          end else begin
            st = ST_MODEM_OK;
          end
        end
      end
    end
    done_nxt = cur_done || emit;
    vld_nxt  = cur_vld;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  // store contents including the byte written this cycle
  for (genvar i = 0; i < VIEW_BYTES; i++) begin : g_view
    if (i < FRAME_BYTES) begin : g_in
      assign view[i] = (wr_en && wr_addr == ADDR_W'(i)) ? dec_byte :
                       (cur_vld[i] ? store_r[i] : 8'h00);
    end else begin : g_out
      assign view[i] = 8'h00;
    end
  end

  // field extraction
  always_comb begin
    result               = '0;
    result.status        = st;
    result.frame_type    = view[POS_TYPE];
    if (st == ST_RX_OK) begin
      for (int k = 0; k < 8; k++) begin
        result.long_address[63-8*k -: 8] = view[POS_LONG+k];
      end
      result.short_address = {view[POS_SHORT], view[POS_SHORT+1]};
      result.options       = view[POS_OPTIONS];
      for (int k = 0; k < 8; k++) begin
        if (k < PAYLOAD_BYTES) begin
          result.payload[8*k +: 8] = view[POS_PAYLOAD+k];
        end
      end
    end else if (st == ST_MODEM_OK) begin
      result.options = view[POS_LONG];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      idx_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      done_r <= 1'b0;
      vld_r  <= '0;
    end else if (step) begin
      esc_r  <= esc_nxt;
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      done_r <= done_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store_r[wr_addr] <= dec_byte;
    end
  end

  a_emit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit |=> done_r)
    else $error("frame not marked finished after a result");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(FRAME_BYTES))
    else $error("byte index beyond store");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && step && !buffer_start |=> $stable(idx_r) && $stable(sum_r) && done_r)
    else $error("state moved after frame finished");

endmodule

`default_nettype wire
